@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that c holds in the same cycle as a.
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");

// Check that c holds in the cycle after a.
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");

`endif

@@ rtl/hcbp_pkg.sv @@
// ---------------------------------------------------------------------------
// hcbp_pkg
// Types and constants of the code bit packer.
// ---------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_ENCODE = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;

   localparam logic [7:0] BIT_SELECT [8] = '{
      8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64, 8'd128
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_EMIT,
      ST_LAST,
      ST_FLUSH
   } state_type;

endpackage

`default_nettype wire

@@ rtl/huffman_code_bit_packer_unit.sv @@
// Encode: a table read, then a scan for the leading one and emission of the
// code bits below it, one bit per cycle while the output is not stalled, then
// release of the final word if one is held. Requests are taken only in the
// idle state, so the unit runs one encode at a time. Load: table write.
// Flush: pending byte, marked last. Output stalls stretch encode and flush.
// Reset clears the sequencer, pending byte and bit count; table undefined.
// ---------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// Code table lookup and serial bit packer, one code bit per unstalled cycle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module huffman_code_bit_packer_unit #(
   parameter int SYMBOLS       = 256,
   parameter int MAX_CODE_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [7:0]  req_symbol,
   input  wire logic [31:0] req_code_word,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last
);
   import hcbp_pkg::*;

   localparam int SYM_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
   localparam int CNT_W = $clog2(MAX_CODE_BITS);
   localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(MAX_CODE_BITS - 1);
   localparam logic [8:0] SYM_LIMIT = 9'(SYMBOLS);

   logic [MAX_CODE_BITS-1:0] code_table [SYMBOLS];
   logic [MAX_CODE_BITS-1:0] rd_data_ff;

   state_type                state_ff, state_in;
   logic [MAX_CODE_BITS-1:0] code_ff, code_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [7:0]               pending_ff, pending_in;
   logic [2:0]               bit_count_ff, bit_count_in;
   logic [7:0]               held_ff, held_in;
   logic                     held_valid_ff, held_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_byte_ff, rsp_byte_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     accept;
   logic                     sym_ok;
   logic                     out_free;
   logic [7:0]               new_byte;
   logic [SYM_W-1:0]         sym_idx;

   assign accept   = req_valid && req_ready;
   assign sym_ok   = {1'b0, req_symbol} < SYM_LIMIT;
   assign sym_idx  = req_symbol[SYM_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign new_byte = pending_ff
                   | (code_ff[MAX_CODE_BITS-1] ? BIT_SELECT[bit_count_ff] : 8'd0);

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (accept && req_op == OP_LOAD && sym_ok) begin
         code_table[sym_idx] <= req_code_word[MAX_CODE_BITS-1:0];
      end
      rd_data_ff <= code_table[sym_idx];
   end

   always_comb begin
      state_in      = state_ff;
      code_in       = code_ff;
      cnt_in        = cnt_ff;
      pending_in    = pending_ff;
      bit_count_in  = bit_count_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_op == OP_ENCODE && sym_ok) begin
                  state_in = ST_READ;
               end else if (req_op == OP_FLUSH) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            code_in  = rd_data_ff;
            cnt_in   = CNT_TOP;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            priority if (code_ff[MAX_CODE_BITS-1]) begin
               code_in  = code_ff << 1;
               state_in = ST_EMIT;
            end else if (cnt_ff == '0) begin
               state_in = ST_LAST;
            end else begin
               code_in = code_ff << 1;
               cnt_in  = cnt_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            priority if (cnt_ff == '0) begin
               state_in = ST_LAST;
            end else if (bit_count_ff != 3'd7) begin
               pending_in   = new_byte;
               bit_count_in = bit_count_ff + 1'b1;
               code_in      = code_ff << 1;
               cnt_in       = cnt_ff - 1'b1;
            end else if (!held_valid_ff || out_free) begin
               if (held_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = held_ff;
                  rsp_last_in  = 1'b0;
               end
               held_in       = new_byte;
               held_valid_in = 1'b1;
               pending_in    = '0;
               bit_count_in  = '0;
               code_in       = code_ff << 1;
               cnt_in        = cnt_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_LAST: begin
            priority if (!held_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = held_ff;
               rsp_last_in   = 1'b1;
               held_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_LAST;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = pending_ff;
               rsp_last_in  = 1'b1;
               pending_in   = '0;
               bit_count_in = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pending_ff    <= '0;
         bit_count_ff  <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pending_ff    <= pending_in;
         bit_count_ff  <= bit_count_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      cnt_ff      <= cnt_in;
      held_ff     <= held_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   `ASSERT_IMPLIES(a_idle_no_held, clock, reset, state_ff == ST_IDLE, !held_valid_ff)
   `ASSERT_IMPLIES(a_mid_word_held, clock, reset, rsp_valid_ff && !rsp_last_ff, held_valid_ff)
   `ASSERT_NEXT(a_flush_seq, clock, reset, accept && req_op == OP_FLUSH, state_ff == ST_FLUSH)

endmodule

`default_nettype wire

@@ sim/tb_huffman_code_bit_packer_unit.sv @@
// ---------------------------------------------------------------------------
// tb_huffman_code_bit_packer_unit
// Self-checking bench for the code bit packer. A directed sequence covers
// empty and single-bit codes, the longest codes, empty and partial flushes
// and the unused op. A long output stall then fills the block while input
// keeps arriving. A random mix of loads, encodes, flushes and unused ops
// follows, with bursts of idling on both channels. Every accepted request
// runs through an internal packer model; its bytes are checked in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_huffman_code_bit_packer_unit;

   import hcbp_pkg::*;

   localparam int SYMBOLS        = 256;
   localparam int MAX_CODE_BITS  = 32;
   localparam int RANDOM_ITEMS   = 230;
   localparam int QUIET_ITEMS    = 40;
   localparam int HOLD_ITEMS     = 16;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 64;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } packed_byte_type;

   class byte_stream_predictor;
      logic [31:0]     code_table [SYMBOLS];
      bit              written [SYMBOLS];
      logic [7:0]      pending;
      logic [2:0]      bit_count;
      packed_byte_type expected_bytes [$];
      int unsigned     mismatches;

      function new();
         pending = 8'd0;
         bit_count = 3'd0;
         mismatches = 0;
         foreach (written[i]) written[i] = 1'b0;
      endfunction

      function void take_item(logic [1:0] op, logic [7:0] sym, logic [31:0] cw);
         logic [31:0]     code;
         logic [63:0]     mask;
         logic [7:0]      made [4];
         packed_byte_type w;
         int              top;
         int              n;
         mask = (64'd1 << MAX_CODE_BITS) - 64'd1;
         case (op)
            OP_LOAD: begin
               if (int'(sym) < SYMBOLS) begin
                  code_table[sym] = cw & mask[31:0];
                  written[sym] = 1'b1;
               end
            end
            OP_FLUSH: begin
               w.out_byte = pending;
               w.last = 1'b1;
               expected_bytes.push_back(w);
               pending = 8'd0;
               bit_count = 3'd0;
            end
            OP_ENCODE: begin
               if (int'(sym) < SYMBOLS) begin
                  code = code_table[sym];
                  top = -1;
                  n = 0;
                  for (int i = 31; i >= 0; i--) begin
                     if (code[i]) begin
                        top = i;
                        break;
                     end
                  end
                  for (int i = top - 1; i >= 0; i--) begin
                     if (code[i]) pending[bit_count] = 1'b1;
                     if (bit_count == 3'd7) begin
                        if (n < 4) made[n] = pending;
                        n++;
                        pending = 8'd0;
                        bit_count = 3'd0;
                     end else begin
                        bit_count = bit_count + 3'd1;
                     end
                  end
                  if (n > 4) n = 4;
                  for (int k = 0; k < n; k++) begin
                     w.out_byte = made[k];
                     w.last = (k == n - 1);
                     expected_bytes.push_back(w);
                  end
               end
            end
            default: begin
            end
         endcase
      endfunction

      function void report(string what, logic [7:0] want, logic [7:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: %s expected %0h actual %0h", what, want, got);
      endfunction

      function void check_byte(logic [7:0] got_byte, logic got_last);
         packed_byte_type want;
         if (expected_bytes.size() == 0) begin
            report("unexpected word, out_byte", 8'd0, got_byte);
         end else begin
            want = expected_bytes.pop_front();
            if (got_byte !== want.out_byte) report("out_byte", want.out_byte, got_byte);
            if (got_last !== want.last) report("last", {7'd0, want.last}, {7'd0, got_last});
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = OP_LOAD;
   logic [7:0]  req_symbol = 8'd0;
   logic [31:0] req_code_word = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;

   byte_stream_predictor board;
   bit          quiet = 1'b0;
   bit          hold_request = 1'b0;
   bit          sender_calm = 1'b0;
   int unsigned idle_cycles = 0;

   huffman_code_bit_packer_unit #(
      .SYMBOLS       (SYMBOLS),
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_symbol    (req_symbol),
      .req_code_word (req_code_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : rsp_side
      int unsigned stall_left;
      int unsigned hold_left;
      int unsigned window;
      bit          calm;
      stall_left = 0;
      hold_left = 0;
      window = 0;
      calm = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_valid && rsp_ready) board.check_byte(rsp_out_byte, rsp_last);
            if (hold_request) begin
               hold_request = 1'b0;
               hold_left = HOLD_CYCLES;
            end
            window++;
            if (window % 64 == 0) calm = ($urandom_range(0, 2) == 0);
            if (hold_left > 0) begin
               hold_left--;
               rsp_ready <= 1'b0;
            end else if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
               stall_left = $urandom_range(1, 12) - 1;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   task automatic send_word(input logic [1:0] op, input logic [7:0] sym,
                            input logic [31:0] cw);
      req_valid <= 1'b1;
      req_op <= op;
      req_symbol <= sym;
      req_code_word <= cw;
      do @(posedge clock); while (!req_ready);
      board.take_item(op, sym, cw);
   endtask

   task automatic maybe_pause();
      int unsigned gap;
      if (!quiet && !sender_calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] random_code();
      int unsigned len;
      logic [31:0] lower;
      if ($urandom_range(0, 19) == 0) return $urandom_range(0, 1);
      if ($urandom_range(0, 9) == 0) return $urandom;
      len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(1, 31);
      lower = $urandom & ((32'd1 << len) - 32'd1);
      return (32'd1 << len) | lower;
   endfunction

   task automatic random_item();
      int unsigned pick;
      logic [7:0]  sym;
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
         send_word(OP_LOAD, 8'($urandom_range(0, SYMBOLS - 1)), random_code());
      end else if (pick < 80) begin
         sym = 8'($urandom_range(0, SYMBOLS - 1));
         while (!board.written[sym]) sym = 8'($urandom_range(0, SYMBOLS - 1));
         send_word(OP_ENCODE, sym, $urandom);
      end else if (pick < 93) begin
         send_word(OP_FLUSH, 8'($urandom_range(0, 255)), $urandom);
      end else begin
         send_word(OP_UNUSED, 8'($urandom_range(0, 255)), $urandom);
      end
   endtask

   initial begin : req_side
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(OP_FLUSH,  8'd0,   32'd0);
      send_word(OP_LOAD,   8'd0,   32'h0000_0000);
      send_word(OP_LOAD,   8'd1,   32'h0000_0001);
      send_word(OP_LOAD,   8'd255, 32'hFFFF_FFFF);
      send_word(OP_LOAD,   8'd128, 32'h8000_0000);
      maybe_pause();
      send_word(OP_LOAD,   8'd2,   32'h0000_0002);
      send_word(OP_LOAD,   8'd3,   32'h0000_0003);
      send_word(OP_LOAD,   8'd85,  32'h0000_01A5);
      send_word(OP_UNUSED, 8'hFF,  32'hFFFF_FFFF);
      send_word(OP_ENCODE, 8'd0,   32'd0);
      send_word(OP_ENCODE, 8'd1,   32'd0);
      send_word(OP_ENCODE, 8'd85,  32'd0);
      maybe_pause();
      send_word(OP_ENCODE, 8'd3,   32'd0);
      send_word(OP_ENCODE, 8'd255, 32'd0);
      send_word(OP_ENCODE, 8'd128, 32'd0);
      send_word(OP_ENCODE, 8'd2,   32'd0);
      send_word(OP_ENCODE, 8'd255, 32'd0);
      maybe_pause();
      send_word(OP_FLUSH,  8'd255, 32'hFFFF_FFFF);
      send_word(OP_FLUSH,  8'd0,   32'd0);
      send_word(OP_ENCODE, 8'd3,   32'd0);
      send_word(OP_FLUSH,  8'd0,   32'd0);
      send_word(OP_UNUSED, 8'd0,   32'd0);
      send_word(OP_ENCODE, 8'd128, 32'd0);

      hold_request = 1'b1;
      for (int k = 0; k < HOLD_ITEMS; k++)
         send_word(OP_ENCODE, 8'd255, $urandom);

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 25 == 0) sender_calm = ($urandom_range(0, 2) == 0);
         if (k >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         random_item();
         maybe_pause();
      end
      req_valid <= 1'b0;

      while (board.expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.expected_bytes.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
